// ===== src/udpdt_pkg.sv =====
package udpdt_pkg;

    typedef logic [1:0] opcode_t;

    localparam opcode_t OP_LOOKUP     = 2'd0;
    localparam opcode_t OP_REGISTER   = 2'd1;
    localparam opcode_t OP_UNREGISTER = 2'd2;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_ALREADY = 2'd1;
    localparam status_t ST_FULL    = 2'd2;
    localparam status_t ST_MISS    = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic commit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== src/udp_req_if.sv =====
interface udp_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] port;
    logic [7:0]  handler_id;

    modport source (output valid, output opcode, output port, output handler_id,
                    input ready);
    modport sink (input valid, input opcode, input port, input handler_id,
                  output ready);
endinterface

// ===== src/udp_rsp_if.sv =====
interface udp_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [2:0] slot;
    logic [7:0] bound_handler;

    modport source (output valid, output status, output slot, output bound_handler,
                    input ready);
    modport sink (input valid, input status, input slot, input bound_handler,
                  output ready);
endinterface

// ===== src/udpdt_ctrl.sv =====
module udpdt_ctrl
    import udpdt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t dp_status,
    output dp_cmd_t    dp_cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        dp_cmd.load   = 1'b0;
        dp_cmd.rd_en  = 1'b0;
        dp_cmd.commit = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dp_cmd.load = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                dp_cmd.rd_en = 1'b1;
                if (dp_status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last read data lands in the trackers
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (dp_status.out_free)
                begin
                    dp_cmd.commit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/udpdt_datapath.sv =====
module udpdt_datapath
    import udpdt_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     dp_cmd,
    output dp_status_t  dp_status,
    input  logic [1:0]  in_opcode,
    input  logic [15:0] in_port,
    input  logic [7:0]  in_handler_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  out_status,
    output logic [2:0]  out_slot,
    output logic [7:0]  out_bound_handler
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    // slot storage, valid bits stand in for the all-zero reset contents
    logic [15:0]      port_mem [SLOTS];
    logic [7:0]       hdl_mem  [SLOTS];
    logic [SLOTS-1:0] valid_reg;

    logic [1:0]    op_reg;
    logic [15:0]   port_reg;
    logic [7:0]    hid_reg;
    logic [IW-1:0] cnt_reg;

    logic          rd_en_reg;
    logic [IW-1:0] rd_idx_reg;
    logic          rd_valid_reg;
    logic [15:0]   rd_port_reg;
    logic [7:0]    rd_hdl_reg;

    logic          hit_reg;
    logic [IW-1:0] hit_idx_reg;
    logic [7:0]    hit_hdl_reg;
    logic          free_reg;
    logic [IW-1:0] free_idx_reg;

    logic          out_valid_reg;
    logic [1:0]    out_status_reg;
    logic [2:0]    out_slot_reg;
    logic [7:0]    out_hdl_reg;

    logic [15:0]   entry_port;
    logic [7:0]    entry_hdl;

    logic          wr_set;
    logic          wr_clr;
    logic [IW-1:0] wr_idx;
    status_t       dec_status;
    logic [IW-1:0] dec_idx;
    logic [7:0]    dec_hdl;

    assign entry_port = rd_valid_reg ? rd_port_reg : 16'd0;
    assign entry_hdl  = rd_valid_reg ? rd_hdl_reg : 8'd0;

    assign dp_status.scan_last = (cnt_reg == LAST_IDX);
    assign dp_status.out_free  = !out_valid_reg || out_ready;

    // item capture and scan address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            rd_en_reg <= 1'b0;
        end
        else
        begin
            rd_en_reg <= dp_cmd.rd_en;
            if (dp_cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (dp_cmd.rd_en)
            begin
                cnt_reg <= cnt_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            op_reg   <= in_opcode;
            port_reg <= in_port;
            hid_reg  <= in_handler_id;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= cnt_reg;
        rd_valid_reg <= valid_reg[cnt_reg];
        rd_port_reg  <= port_mem[cnt_reg];
        rd_hdl_reg   <= hdl_mem[cnt_reg];
    end

    // lowest match and lowest free slot trackers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (dp_cmd.load)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (rd_en_reg)
        begin
            if (!hit_reg && entry_port == port_reg)
            begin
                hit_reg <= 1'b1;
            end
            if (!free_reg && entry_port == 16'd0)
            begin
                free_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en_reg && !hit_reg && entry_port == port_reg)
        begin
            hit_idx_reg <= rd_idx_reg;
            hit_hdl_reg <= entry_hdl;
        end
        if (rd_en_reg && !free_reg && entry_port == 16'd0)
        begin
            free_idx_reg <= rd_idx_reg;
        end
    end

    // outcome of the finished scan
    always_comb
    begin
        wr_set     = 1'b0;
        wr_clr     = 1'b0;
        wr_idx     = hit_idx_reg;
        dec_status = ST_MISS;
        dec_idx    = '0;
        dec_hdl    = 8'd0;
        case (op_reg)
            OP_LOOKUP:
            begin
                if (hit_reg && port_reg != 16'd0)
                begin
                    dec_status = ST_OK;
                    dec_idx    = hit_idx_reg;
                    dec_hdl    = hit_hdl_reg;
                end
            end
            OP_REGISTER:
            begin
                if (hit_reg)
                begin
                    dec_status = ST_ALREADY;
                end
                else if (!free_reg)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    dec_status = ST_OK;
                    dec_idx    = free_idx_reg;
                    wr_set     = 1'b1;
                    wr_idx     = free_idx_reg;
                end
            end
            OP_UNREGISTER:
            begin
                if (hit_reg)
                begin
                    dec_status = ST_OK;
                    dec_idx    = hit_idx_reg;
                    wr_clr     = 1'b1;
                end
            end
            default:
            begin
                dec_status = ST_MISS;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.commit && wr_set)
        begin
            port_mem[wr_idx] <= port_reg;
            hdl_mem[wr_idx]  <= hid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (dp_cmd.commit && (wr_set || wr_clr))
        begin
            valid_reg[wr_idx] <= wr_set;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dp_cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.commit)
        begin
            out_status_reg <= dec_status;
            out_slot_reg   <= 3'(dec_idx);
            out_hdl_reg    <= dec_hdl;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_status        = out_status_reg;
    assign out_slot          = out_slot_reg;
    assign out_bound_handler = out_hdl_reg;

endmodule

// ===== src/udp_port_demux_table_core.sv =====
// udp port demultiplex table: binds udp ports to handler ids in SLOTS slots
// a request is taken only while idle, so the next request waits until the response
// to the last one has been committed, after the slot walk through the single
//   registered read port of the slot memory
// reset: rst_n clears all slot valid bits at once, every slot reads as free
//   with handler zero; no clearing pass
module udp_port_demux_table_core
    import udpdt_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    udp_req_if.sink   req,
    udp_rsp_if.source rsp
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // controller: idle, walk the slots, drain the read pipe, commit
    udpdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    // datapath: slot memory, match trackers, decision and output register
    // one walk finds both the lowest matching slot and the lowest free slot
    udpdt_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .dp_cmd            (dp_cmd),
        .dp_status         (dp_status),
        .in_opcode         (req.opcode),
        .in_port           (req.port),
        .in_handler_id     (req.handler_id),
        .out_valid         (rsp.valid),
        .out_ready         (rsp.ready),
        .out_status        (rsp.status),
        .out_slot          (rsp.slot),
        .out_bound_handler (rsp.bound_handler)
    );

endmodule
